// ===== rtl/core/point_range_box_ground_filter_core_defines.svh =====
// assertion macros shared by the point filter rtl
`ifndef POINT_RANGE_BOX_GROUND_FILTER_CORE_DEFINES_SVH
`define POINT_RANGE_BOX_GROUND_FILTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PRBGF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PRBGF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/prbgf_pkg.sv =====
// shared types and constants for the point range, box and ground filter
package prbgf_pkg;

  localparam int COORD_BITS     = 20;
  localparam int COUNT_BITS     = 22;
  localparam int OUT_COUNT_BITS = 22;
  localparam int RANGE_BITS     = 19;
  localparam int MODE_BITS      = 2;
  localparam int BOUND_BITS     = 20;
  localparam int BOX_BITS       = 2 * BOUND_BITS;
  localparam int GROUND_BITS    = 20;
  localparam int DATA_BITS      = 64;
  localparam int ADDR_BITS      = 6;
  localparam int IDX_LSB        = 3;
  localparam int IDX_BITS       = ADDR_BITS - IDX_LSB;
  localparam int REASON_BITS    = 3;

  localparam int RANGE_SQ_BITS  = 2 * RANGE_BITS;
  localparam int DIST_SQ_BITS   = 2 * COORD_BITS;
  localparam int CMP_BITS       = (DIST_SQ_BITS > RANGE_SQ_BITS) ? DIST_SQ_BITS
                                                                  : RANGE_SQ_BITS;
  localparam int BOX_CMP_BITS   = (COORD_BITS > BOUND_BITS) ? COORD_BITS : BOUND_BITS;
  localparam int GND_CMP_BITS   = (COORD_BITS > GROUND_BITS) ? COORD_BITS : GROUND_BITS;

  localparam int MODE_BOX_BIT    = 0;
  localparam int MODE_GROUND_BIT = 1;

  localparam logic [RANGE_BITS-1:0]         MIN_RANGE_RST = 19'd500;
  localparam logic [RANGE_BITS-1:0]         MAX_RANGE_RST = 19'd100000;
  localparam logic [MODE_BITS-1:0]          MODE_RST      = 2'd1;
  localparam logic [BOX_BITS-1:0]           BOX_X_RST     = 40'd52428800000;
  localparam logic [BOX_BITS-1:0]           BOX_Y_RST     = 40'd10486798576;
  localparam logic [BOX_BITS-1:0]           BOX_Z_RST     = 40'd10486806576;
  localparam logic signed [GROUND_BITS-1:0] GROUND_RST    = -20'sd1000;

  typedef enum logic [IDX_BITS-1:0] {
    REG_MIN_RANGE = 3'd0,
    REG_MAX_RANGE = 3'd1,
    REG_MODE      = 3'd2,
    REG_BOX_X     = 3'd3,
    REG_BOX_Y     = 3'd4,
    REG_BOX_Z     = 3'd5,
    REG_GROUND    = 3'd6
  } reg_idx_t;

  typedef enum logic [REASON_BITS-1:0] {
    RSN_KEEP       = 3'd0,
    RSN_NOT_FINITE = 3'd1,
    RSN_RANGE      = 3'd2,
    RSN_BOX        = 3'd3,
    RSN_GROUND     = 3'd4
  } reason_t;

  typedef struct packed {
    logic [RANGE_SQ_BITS-1:0] min_sq;
    logic [RANGE_SQ_BITS-1:0] max_sq;
    logic [MODE_BITS-1:0]     mode;
    logic [BOX_BITS-1:0]      box_x;
    logic [BOX_BITS-1:0]      box_y;
    logic [BOX_BITS-1:0]      box_z;
    logic [GROUND_BITS-1:0]   ground;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
    logic                  finite;
    logic                  last;
  } point_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] total;
    logic [COUNT_BITS-1:0] kept;
    logic [COUNT_BITS-1:0] range_drop;
    logic [COUNT_BITS-1:0] box_drop;
    logic [COUNT_BITS-1:0] ground_drop;
  } counts_t;

endpackage

// ===== rtl/core/point_range_box_ground_filter_core.sv =====
// top level of the lidar point range, crop box and ground filter
//
// one word in on the in_ channel is one lidar point: signed millimetre
// coordinates, a finite flag and a last-point flag. one word out on the
// out_ channel follows for every point: keep flag, drop reason, the five
// running per-cloud counts (saturating, including this point) and
// cloud_done, which copies last_point so the counts are cloud totals.
// checks run in order: not finite, range (squared distance against squared
// limits), box when mode bit 0 is set, ground when mode bit 1 is set.
// a taken point passes through one input register, then the checks and
// counters into the output register, where out_valid rises. throughput is
// one point per cycle while the receiver does not stall; the three 20x20
// squares and their sum set the cycle.
// when the receiver stalls, the output word holds and one more point may
// sit in the input register; in_stall rises only once both are full.
// the user must write limits over the apb port only while the block is idle;
// the block does not enforce it. range squares are registered. reset loads
// the default limits, clears both valid flags and zeroes every counter.
`include "point_range_box_ground_filter_core_defines.svh"
module point_range_box_ground_filter_core import prbgf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  // point input
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [COORD_BITS-1:0]     in_x_mm,
  input  logic [COORD_BITS-1:0]     in_y_mm,
  input  logic [COORD_BITS-1:0]     in_z_mm,
  input  logic                      in_coords_finite,
  input  logic                      in_last_point,
  // result output
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_keep,
  output logic [REASON_BITS-1:0]    out_drop_reason,
  output logic [OUT_COUNT_BITS-1:0] out_points_in,
  output logic [OUT_COUNT_BITS-1:0] out_points_kept,
  output logic [OUT_COUNT_BITS-1:0] out_dropped_range,
  output logic [OUT_COUNT_BITS-1:0] out_dropped_box,
  output logic [OUT_COUNT_BITS-1:0] out_dropped_ground,
  output logic                      out_cloud_done,
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_BITS-1:0]      paddr,
  input  logic [DATA_BITS-1:0]      pwdata,
  output logic [DATA_BITS-1:0]      prdata,
  output logic                      pready
);

  cfg_t    cfg;
  point_t  pt_r;
  logic    pt_valid_r;
  logic    pt_valid_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  reason_t reason;
  reason_t reason_r;
  counts_t shown;
  counts_t counts_r;
  logic    last_r;
  logic    in_take;
  logic    out_hold;
  logic    adv;

  prbgf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // flow control: output word held while stalled, input register moves
  // forward whenever the output register is free or being emptied
  assign out_hold = out_valid_r & out_stall;
  assign adv      = pt_valid_r & ~out_hold;
  assign in_stall = pt_valid_r & out_hold;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    pt_valid_nxt = pt_valid_r;
    if (in_take) begin
      pt_valid_nxt = 1'b1;
    end else if (adv) begin
      pt_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_hold) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pt_valid_r  <= pt_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register, payload only
  always_ff @(posedge clk) begin
    if (in_take) begin
      pt_r.x      <= in_x_mm;
      pt_r.y      <= in_y_mm;
      pt_r.z      <= in_z_mm;
      pt_r.finite <= in_coords_finite;
      pt_r.last   <= in_last_point;
    end
  end

  prbgf_classify u_classify (
    .pt_i     (pt_r),
    .cfg_i    (cfg),
    .reason_o (reason)
  );

  prbgf_counters u_counters (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv_i    (adv),
    .reason_i (reason),
    .last_i   (pt_r.last),
    .shown_o  (shown)
  );

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      reason_r <= reason;
      counts_r <= shown;
      last_r   <= pt_r.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_keep           = (reason_r == RSN_KEEP);
  assign out_drop_reason    = reason_r;
  assign out_points_in      = OUT_COUNT_BITS'(counts_r.total);
  assign out_points_kept    = OUT_COUNT_BITS'(counts_r.kept);
  assign out_dropped_range  = OUT_COUNT_BITS'(counts_r.range_drop);
  assign out_dropped_box    = OUT_COUNT_BITS'(counts_r.box_drop);
  assign out_dropped_ground = OUT_COUNT_BITS'(counts_r.ground_drop);
  assign out_cloud_done     = last_r;

  `PRBGF_ASSERT_SAME(a_stall_only_when_full, in_stall,
    pt_valid_r && out_valid_r && out_stall,
    "input stalled without back-pressure from a full output")
  `PRBGF_ASSERT_NEXT(a_pending_point_delivered, pt_valid_r && !out_hold, out_valid_r,
    "point in the input register not moved to the output")
  `PRBGF_ASSERT_NEXT(a_output_drains, out_valid_r && !out_stall && !pt_valid_r,
    !out_valid_r, "result repeated after it was taken")

endmodule

// ===== rtl/core/prbgf_cfg_regs.sv =====
// apb register file with registered squares of the range limits
module prbgf_cfg_regs import prbgf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  logic [RANGE_BITS-1:0]    min_range_r;
  logic [RANGE_BITS-1:0]    max_range_r;
  logic [MODE_BITS-1:0]     mode_r;
  logic [BOX_BITS-1:0]      box_x_r;
  logic [BOX_BITS-1:0]      box_y_r;
  logic [BOX_BITS-1:0]      box_z_r;
  logic [GROUND_BITS-1:0]   ground_r;
  logic [RANGE_SQ_BITS-1:0] min_sq_r;
  logic [RANGE_SQ_BITS-1:0] max_sq_r;
  logic                     wr_en;
  reg_idx_t                 idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:IDX_LSB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r <= MIN_RANGE_RST;
      max_range_r <= MAX_RANGE_RST;
      mode_r      <= MODE_RST;
      box_x_r     <= BOX_X_RST;
      box_y_r     <= BOX_Y_RST;
      box_z_r     <= BOX_Z_RST;
      ground_r    <= GROUND_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MIN_RANGE: min_range_r <= pwdata[RANGE_BITS-1:0];
        REG_MAX_RANGE: max_range_r <= pwdata[RANGE_BITS-1:0];
        REG_MODE:      mode_r      <= pwdata[MODE_BITS-1:0];
        REG_BOX_X:     box_x_r     <= pwdata[BOX_BITS-1:0];
        REG_BOX_Y:     box_y_r     <= pwdata[BOX_BITS-1:0];
        REG_BOX_Z:     box_z_r     <= pwdata[BOX_BITS-1:0];
        REG_GROUND:    ground_r    <= pwdata[GROUND_BITS-1:0];
        default: ;
      endcase
    end
  end

  // squares are registered and follow the limits in the next cycle
  always_ff @(posedge clk) begin
    min_sq_r <= RANGE_SQ_BITS'(min_range_r * min_range_r);
    max_sq_r <= RANGE_SQ_BITS'(max_range_r * max_range_r);
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MIN_RANGE: prdata = DATA_BITS'(min_range_r);
      REG_MAX_RANGE: prdata = DATA_BITS'(max_range_r);
      REG_MODE:      prdata = DATA_BITS'(mode_r);
      REG_BOX_X:     prdata = DATA_BITS'(box_x_r);
      REG_BOX_Y:     prdata = DATA_BITS'(box_y_r);
      REG_BOX_Z:     prdata = DATA_BITS'(box_z_r);
      REG_GROUND:    prdata = DATA_BITS'(ground_r);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.min_sq = min_sq_r;
  assign cfg_o.max_sq = max_sq_r;
  assign cfg_o.mode   = mode_r;
  assign cfg_o.box_x  = box_x_r;
  assign cfg_o.box_y  = box_y_r;
  assign cfg_o.box_z  = box_z_r;
  assign cfg_o.ground = ground_r;

endmodule

// ===== rtl/core/prbgf_classify.sv =====
// not-finite, range, box and ground checks for one registered point
module prbgf_classify import prbgf_pkg::*; (
  input  point_t  pt_i,
  input  cfg_t    cfg_i,
  output reason_t reason_o
);

  function automatic logic in_box(input logic [COORD_BITS-1:0] v,
                                  input logic [BOX_BITS-1:0]   b);
    logic signed [BOX_CMP_BITS-1:0] vv;
    logic signed [BOX_CMP_BITS-1:0] lo;
    logic signed [BOX_CMP_BITS-1:0] hi;
    vv = BOX_CMP_BITS'($signed(v));
    lo = BOX_CMP_BITS'($signed(b[BOUND_BITS-1:0]));
    hi = BOX_CMP_BITS'($signed(b[BOX_BITS-1:BOUND_BITS]));
    return (vv >= lo) && (vv <= hi);
  endfunction

  function automatic logic [COORD_BITS-1:0] mag(input logic [COORD_BITS-1:0] v);
    return v[COORD_BITS-1] ? COORD_BITS'(-v) : v;
  endfunction

  logic [COORD_BITS-1:0]          ax, ay, az;
  logic [DIST_SQ_BITS-1:0]        sq_x, sq_y, sq_z, dist_sq;
  logic                           range_fail, box_fail, ground_fail;
  logic signed [GND_CMP_BITS-1:0] z_ext, gnd_ext;

  assign ax = mag(pt_i.x);
  assign ay = mag(pt_i.y);
  assign az = mag(pt_i.z);

  // three independent squares, sum cannot overflow twice the coordinate width
  assign sq_x    = DIST_SQ_BITS'(ax) * DIST_SQ_BITS'(ax);
  assign sq_y    = DIST_SQ_BITS'(ay) * DIST_SQ_BITS'(ay);
  assign sq_z    = DIST_SQ_BITS'(az) * DIST_SQ_BITS'(az);
  assign dist_sq = sq_x + sq_y + sq_z;

  assign range_fail = (CMP_BITS'(dist_sq) < CMP_BITS'(cfg_i.min_sq)) ||
                      (CMP_BITS'(dist_sq) > CMP_BITS'(cfg_i.max_sq));

  assign box_fail = cfg_i.mode[MODE_BOX_BIT] &&
                    !(in_box(pt_i.x, cfg_i.box_x) && in_box(pt_i.y, cfg_i.box_y) &&
                      in_box(pt_i.z, cfg_i.box_z));

  assign z_ext       = GND_CMP_BITS'($signed(pt_i.z));
  assign gnd_ext     = GND_CMP_BITS'($signed(cfg_i.ground));
  assign ground_fail = cfg_i.mode[MODE_GROUND_BIT] && (z_ext < gnd_ext);

  always_comb begin
    priority if (!pt_i.finite) begin
      reason_o = RSN_NOT_FINITE;
    end else if (range_fail) begin
      reason_o = RSN_RANGE;
    end else if (box_fail) begin
      reason_o = RSN_BOX;
    end else if (ground_fail) begin
      reason_o = RSN_GROUND;
    end else begin
      reason_o = RSN_KEEP;
    end
  end

endmodule

// ===== rtl/core/prbgf_counters.sv =====
// per-cloud saturating counters, cleared after the last point
`include "point_range_box_ground_filter_core_defines.svh"
module prbgf_counters import prbgf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv_i,
  input  reason_t reason_i,
  input  logic    last_i,
  output counts_t shown_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c,
                                                    input logic                  en);
    return (en && (c != COUNT_TOP)) ? c + 1'b1 : c;
  endfunction

  counts_t cnt_r;
  counts_t cnt_nxt;

  // counts including the current point, as shown on the result
  always_comb begin
    shown_o.total       = sat_inc(cnt_r.total, 1'b1);
    shown_o.kept        = sat_inc(cnt_r.kept, reason_i == RSN_KEEP);
    shown_o.range_drop  = sat_inc(cnt_r.range_drop, reason_i == RSN_RANGE);
    shown_o.box_drop    = sat_inc(cnt_r.box_drop, reason_i == RSN_BOX);
    shown_o.ground_drop = sat_inc(cnt_r.ground_drop, reason_i == RSN_GROUND);
  end

  assign cnt_nxt = last_i ? '0 : shown_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (adv_i) begin
      cnt_r <= cnt_nxt;
    end
  end

  `PRBGF_ASSERT_SAME(a_counts_bounded, 1'b1,
    (cnt_r.kept <= cnt_r.total) && (cnt_r.range_drop <= cnt_r.total) &&
    (cnt_r.box_drop <= cnt_r.total) && (cnt_r.ground_drop <= cnt_r.total),
    "a class count exceeds the input count")
  `PRBGF_ASSERT_NEXT(a_clear_after_last, adv_i && last_i, cnt_r == '0,
    "counters not cleared after the last point of a cloud")

endmodule

// ===== tb/point_range_box_ground_filter_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the lidar point range, crop box and ground filter core
module point_range_box_ground_filter_core_tb import prbgf_pkg::*;;

  // receiver hold-off used to back the block up into its input
  localparam int HOLD_CYCLES  = 300;
  // cycles with no word moving and no register access before giving up
  localparam int QUIET_LIMIT  = 5000;
  // settle time after the last word
  localparam int TAIL_CYCLES  = 8;
  localparam int IDLE_PERCENT = 22;

  // filter mode masks built from the package bit positions
  localparam logic [MODE_BITS-1:0] NO_CHECKS = '0;
  localparam logic [MODE_BITS-1:0] BOX_ON    = MODE_BITS'(1) << MODE_BOX_BIT;
  localparam logic [MODE_BITS-1:0] GROUND_ON = MODE_BITS'(1) << MODE_GROUND_BIT;
  localparam logic [MODE_BITS-1:0] BOTH_ON   = BOX_ON | GROUND_ON;

  // one result word as seen on the out_ channel
  typedef struct {
    logic                      keep;
    logic [REASON_BITS-1:0]    reason;
    logic [OUT_COUNT_BITS-1:0] total, kept, range_drop, box_drop, ground_drop;
    logic                      done;
  } point_verdict_t;

  // predicts the verdict for each accepted point and checks result words in order
  class verdict_board;
    logic [RANGE_BITS-1:0]  min_range, max_range;
    logic [MODE_BITS-1:0]   mode;
    logic [BOX_BITS-1:0]    box_x, box_y, box_z;
    logic [GROUND_BITS-1:0] ground;
    counts_t                tally;
    point_verdict_t         verdict_q[$];
    int                     errors;

    function new();
      min_range = MIN_RANGE_RST;
      max_range = MAX_RANGE_RST;
      mode      = MODE_RST;
      box_x     = BOX_X_RST;
      box_y     = BOX_Y_RST;
      box_z     = BOX_Z_RST;
      ground    = GROUND_RST;
      tally     = '0;
      errors    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_BITS-1:0] val);
      case (idx)
        REG_MIN_RANGE: min_range = val[RANGE_BITS-1:0];
        REG_MAX_RANGE: max_range = val[RANGE_BITS-1:0];
        REG_MODE:      mode      = val[MODE_BITS-1:0];
        REG_BOX_X:     box_x     = val[BOX_BITS-1:0];
        REG_BOX_Y:     box_y     = val[BOX_BITS-1:0];
        REG_BOX_Z:     box_z     = val[BOX_BITS-1:0];
        REG_GROUND:    ground    = val[GROUND_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] c);
      return (&c) ? c : c + 1'b1;
    endfunction

    function bit in_bounds(longint v, logic [BOX_BITS-1:0] b);
      longint lo, hi;
      lo = $signed(b[BOUND_BITS-1:0]);
      hi = $signed(b[BOX_BITS-1:BOUND_BITS]);
      return (v >= lo) && (v <= hi);
    endfunction

    function void note_point(point_t p);
      longint         xs, ys, zs, dist_sq, lo_sq, hi_sq;
      reason_t        rsn;
      point_verdict_t v;
      xs      = $signed(p.x);
      ys      = $signed(p.y);
      zs      = $signed(p.z);
      dist_sq = xs * xs + ys * ys + zs * zs;
      lo_sq   = longint'(min_range) * longint'(min_range);
      hi_sq   = longint'(max_range) * longint'(max_range);
      tally.total = bump(tally.total);
      if (!p.finite) begin
        rsn = RSN_NOT_FINITE;
      end else if (dist_sq < lo_sq || dist_sq > hi_sq) begin
        rsn = RSN_RANGE;
        tally.range_drop = bump(tally.range_drop);
      end else if (mode[MODE_BOX_BIT] && !(in_bounds(xs, box_x) && in_bounds(ys, box_y) &&
                                           in_bounds(zs, box_z))) begin
        rsn = RSN_BOX;
        tally.box_drop = bump(tally.box_drop);
      end else if (mode[MODE_GROUND_BIT] && zs < longint'($signed(ground))) begin
        rsn = RSN_GROUND;
        tally.ground_drop = bump(tally.ground_drop);
      end else begin
        rsn = RSN_KEEP;
        tally.kept = bump(tally.kept);
      end
      v.keep        = (rsn == RSN_KEEP);
      v.reason      = rsn;
      v.total       = tally.total;
      v.kept        = tally.kept;
      v.range_drop  = tally.range_drop;
      v.box_drop    = tally.box_drop;
      v.ground_drop = tally.ground_drop;
      v.done        = p.last;
      verdict_q.insert(verdict_q.size(), v);
      if (p.last) tally = '0;
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_word(point_verdict_t got);
      point_verdict_t want;
      if (verdict_q.size() == 0) begin
        $error("result word with no point waiting for it");
        errors++;
        return;
      end
      want = verdict_q.pop_front();
      compare_field("keep",           32'(want.keep),        32'(got.keep));
      compare_field("drop_reason",    32'(want.reason),      32'(got.reason));
      compare_field("points_in",      32'(want.total),       32'(got.total));
      compare_field("points_kept",    32'(want.kept),        32'(got.kept));
      compare_field("dropped_range",  32'(want.range_drop),  32'(got.range_drop));
      compare_field("dropped_box",    32'(want.box_drop),    32'(got.box_drop));
      compare_field("dropped_ground", 32'(want.ground_drop), 32'(got.ground_drop));
      compare_field("cloud_done",     32'(want.done),        32'(got.done));
    endfunction
  endclass

  // block ports, all inputs known from time zero
  logic                      clk              = 1'b0;
  logic                      rst_n            = 1'b0;
  logic                      in_valid         = 1'b0;
  logic                      in_stall;
  logic [COORD_BITS-1:0]     in_x_mm          = '0;
  logic [COORD_BITS-1:0]     in_y_mm          = '0;
  logic [COORD_BITS-1:0]     in_z_mm          = '0;
  logic                      in_coords_finite = 1'b0;
  logic                      in_last_point    = 1'b0;
  logic                      out_valid;
  logic                      out_stall        = 1'b0;
  logic                      out_keep;
  logic [REASON_BITS-1:0]    out_drop_reason;
  logic [OUT_COUNT_BITS-1:0] out_points_in;
  logic [OUT_COUNT_BITS-1:0] out_points_kept;
  logic [OUT_COUNT_BITS-1:0] out_dropped_range;
  logic [OUT_COUNT_BITS-1:0] out_dropped_box;
  logic [OUT_COUNT_BITS-1:0] out_dropped_ground;
  logic                      out_cloud_done;
  logic                      psel             = 1'b0;
  logic                      penable          = 1'b0;
  logic                      pwrite           = 1'b0;
  logic [ADDR_BITS-1:0]      paddr            = '0;
  logic [DATA_BITS-1:0]      pwdata           = '0;
  logic [DATA_BITS-1:0]      prdata;
  logic                      pready;

  verdict_board board;

  // idling controls: sender gaps are read by the stimulus itself,
  // receiver gaps and hold-off requests are picked up by the receiver process
  bit tx_gaps   = 1'b1;
  bit rx_gaps   = 1'b1;
  int hold_ask  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // run statistics for the closing summary
  int words_seen   = 0;
  int clouds_done  = 0;
  int stall_hits   = 0;
  int settings     = 0;
  int quiet_cycles = 0;
  int reason_seen[8];

  point_range_box_ground_filter_core DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(posedge clk) begin : receiver
    if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_gaps && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // both channels are sampled here with the values that stood before the edge,
  // so the prediction never depends on event order within the step
  always @(posedge clk) begin : port_watch
    point_t         took;
    point_verdict_t word;
    if (rst_n && in_valid && !in_stall) begin
      took = '{in_x_mm, in_y_mm, in_z_mm, in_coords_finite, in_last_point};
      board.note_point(took);
    end
    if (rst_n && in_valid && in_stall) stall_hits++;
    if (rst_n && out_valid && !out_stall) begin
      word = '{out_keep, out_drop_reason, out_points_in, out_points_kept,
               out_dropped_range, out_dropped_box, out_dropped_ground, out_cloud_done};
      board.check_word(word);
      words_seen++;
      if (!$isunknown(out_drop_reason)) reason_seen[out_drop_reason]++;
      if (out_cloud_done === 1'b1) clouds_done++;
    end
  end

  // watchdog: any word moving or register access counts as progress
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one point, with a random gap first, and hold it until it is taken
  task automatic send_point(input point_t p);
    if (tx_gaps)
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid         <= 1'b1;
    in_x_mm          <= p.x;
    in_y_mm          <= p.y;
    in_z_mm          <= p.z;
    in_coords_finite <= p.finite;
    in_last_point    <= p.last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_xyz(input int x, y, z, input bit finite, last);
    point_t p;
    p = '{COORD_BITS'(x), COORD_BITS'(y), COORD_BITS'(z), finite, last};
    send_point(p);
  endtask

  // wait until every expected word has come out, then let the pipeline empty;
  // one edge first so the last accepted point is already on the board
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup then access; psel stays high across back-to-back writes
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(idx) << IDX_LSB;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, val);
  endtask

  function automatic logic [BOX_BITS-1:0] box_of(input int lo, hi);
    return {BOUND_BITS'(hi), BOUND_BITS'(lo)};
  endfunction

  // new limit set, written only once the block has gone idle
  task automatic apply_limits(input int min_r, max_r, input logic [MODE_BITS-1:0] mode,
                              input logic [BOX_BITS-1:0] bx, by, bz, input int gnd);
    drain();
    write_reg(REG_MIN_RANGE, DATA_BITS'(min_r));
    write_reg(REG_MAX_RANGE, DATA_BITS'(max_r));
    write_reg(REG_MODE,      DATA_BITS'(mode));
    write_reg(REG_BOX_X,     DATA_BITS'(bx));
    write_reg(REG_BOX_Y,     DATA_BITS'(by));
    write_reg(REG_BOX_Z,     DATA_BITS'(bz));
    // sign-extended on purpose: only the low bits should land
    write_reg(REG_GROUND,    DATA_BITS'(gnd));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings++;
  endtask

  task automatic random_limits();
    int lo[3], hi[3], t;
    for (int a = 0; a < 3; a++) begin
      lo[a] = -int'($urandom_range(60000));
      hi[a] = int'($urandom_range(60000));
      // now and then an inverted box side
      if ($urandom_range(7) == 0) begin
        t = lo[a];
        lo[a] = hi[a];
        hi[a] = t;
      end
    end
    apply_limits(($urandom_range(9) == 0) ? $urandom_range(524287) : $urandom_range(3000),
                 ($urandom_range(9) == 0) ? $urandom_range(524287)
                                          : $urandom_range(524287, 20000),
                 MODE_BITS'($urandom_range(3)),
                 box_of(lo[0], hi[0]), box_of(lo[1], hi[1]), box_of(lo[2], hi[2]),
                 int'($urandom_range(4000)) - 3000);
  endtask

  // a coordinate inside one box side, or its minimum if the side is inverted
  function automatic logic [COORD_BITS-1:0] in_span(input logic [BOX_BITS-1:0] b);
    longint lo, hi;
    lo = $signed(b[BOUND_BITS-1:0]);
    hi = $signed(b[BOX_BITS-1:BOUND_BITS]);
    if (hi < lo) return COORD_BITS'(lo);
    return COORD_BITS'(lo + longint'($urandom_range(32'(hi - lo))));
  endfunction

  function automatic logic [COORD_BITS-1:0] nudge(input logic [COORD_BITS-1:0] v);
    return v + COORD_BITS'($urandom_range(4)) - COORD_BITS'(2);
  endfunction

  // mostly points that sit in or near the current limits, so every check
  // sees traffic on both sides of its threshold; the rest is raw noise
  function automatic point_t random_point();
    point_t                p;
    int                    pick, axis, r;
    logic [BOX_BITS-1:0]   sides;
    logic [COORD_BITS-1:0] v;
    pick = $urandom_range(99);
    axis = $urandom_range(2);
    p.x  = in_span(board.box_x);
    p.y  = in_span(board.box_y);
    p.z  = in_span(board.box_z);
    if (pick < 10) begin
      p.x = COORD_BITS'($urandom);
      p.y = COORD_BITS'($urandom);
      p.z = COORD_BITS'($urandom);
    end else if (pick < 55) begin
      // well inside the box
    end else if (pick < 70) begin
      sides = (axis == 0) ? board.box_x : (axis == 1) ? board.box_y : board.box_z;
      v = nudge($urandom_range(1) ? sides[BOX_BITS-1:BOUND_BITS] : sides[BOUND_BITS-1:0]);
      if (axis == 0) p.x = v;
      else if (axis == 1) p.y = v;
      else p.z = v;
    end else if (pick < 80) begin
      // on one axis, a hair either side of a range limit
      r = int'($urandom_range(1) ? board.max_range : board.min_range) +
          int'($urandom_range(4)) - 2;
      v = COORD_BITS'($urandom_range(1) ? -r : r);
      p.x = (axis == 0) ? v : '0;
      p.y = (axis == 1) ? v : '0;
      p.z = (axis == 2) ? v : '0;
    end else if (pick < 90) begin
      p.z = nudge(board.ground);
    end else begin
      p.x = COORD_BITS'(int'($urandom_range(1400)) - 700);
      p.y = COORD_BITS'(int'($urandom_range(1400)) - 700);
      p.z = COORD_BITS'(int'($urandom_range(1400)) - 700);
    end
    p.finite = ($urandom_range(99) >= 8);
    p.last   = ($urandom_range(39) == 0);
    return p;
  endfunction

  task automatic run_points(input int n);
    repeat (n) send_point(random_point());
  endtask

  initial begin : stimulus
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits: range 500..100000, box only, x 0..50000, y +-10000, z -2000..10000
    send_xyz(0, 0, 0, 1, 0);              // nearer than min range
    send_xyz(500, 0, 0, 1, 0);            // exactly min range is kept
    send_xyz(499, 0, 0, 1, 0);
    send_xyz(300, 400, 0, 1, 0);          // 500 along a diagonal
    send_xyz(50000, 0, 0, 1, 0);          // box maximum is inclusive
    send_xyz(50001, 0, 0, 1, 0);
    send_xyz(-1, 0, 600, 1, 0);           // just below box x minimum
    send_xyz(3000, 10000, 10000, 1, 0);
    send_xyz(3000, -10001, 0, 1, 0);
    send_xyz(3000, 0, -2000, 1, 0);       // below ground height, ground check off
    send_xyz(3000, 0, -2001, 1, 0);
    send_xyz(100000, 0, 0, 1, 0);         // on max range, then fails the box
    send_xyz(100001, 0, 0, 1, 0);
    send_xyz(-524288, -524288, -524288, 1, 0);
    send_xyz(524287, 524287, 524287, 1, 0);
    send_xyz(-524288, 524287, -524288, 0, 0);  // not finite, coordinates ignored
    send_xyz(0, 0, 0, 0, 1);              // cloud closed by a non-finite point
    send_xyz(1000, 0, 0, 1, 1);           // single-point cloud
    send_xyz(1000, 0, 0, 1, 0);           // counts start again from one

    // both checks on; box rejects before ground does
    apply_limits(1000, 80000, BOTH_ON, box_of(-40000, 60000), box_of(-15000, 15000),
                 box_of(-3000, 8000), -1000);
    send_xyz(5000, 0, -1001, 1, 0);
    send_xyz(5000, 0, -1000, 1, 0);
    send_xyz(5000, 0, -3001, 1, 0);
    send_xyz(5000, 0, 0, 1, 1);

    // long receiver hold-off with the sender pushing flat out
    tx_gaps = 1'b0;
    hold_ask <= hold_ask + 1;
    run_points(40);
    tx_gaps = 1'b1;
    run_points(220);

    // widest limits and no idling on either side
    apply_limits(0, 524287, BOTH_ON, box_of(-524288, 524287), box_of(-524288, 524287),
                 box_of(-524288, 524287), -524288);
    tx_gaps = 1'b0;
    rx_gaps <= 1'b0;
    send_xyz(0, 0, 0, 1, 0);
    send_xyz(524287, 0, 0, 1, 0);
    send_xyz(-524288, 0, 0, 1, 0);
    run_points(280);
    tx_gaps = 1'b1;
    rx_gaps <= 1'b1;

    // inverted range: every finite point goes on range
    apply_limits(524287, 0, GROUND_ON, BOX_X_RST, BOX_Y_RST, BOX_Z_RST, 0);
    run_points(80);

    // zero-width range shell
    apply_limits(5000, 5000, NO_CHECKS, BOX_X_RST, BOX_Y_RST, BOX_Z_RST, 0);
    send_xyz(0, -5000, 0, 1, 0);
    run_points(60);

    // inverted box side, highest ground height
    apply_limits(0, 524287, BOX_ON, box_of(100, -100), box_of(-20000, 20000),
                 box_of(-5000, 5000), 524287);
    run_points(150);

    // ground only, everything in range lies below ground
    apply_limits(200, 300000, GROUND_ON, BOX_X_RST, BOX_Y_RST, BOX_Z_RST, 524287);
    run_points(150);

    repeat (5) begin
      random_limits();
      run_points(140);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d result words over %0d finished clouds and %0d limit settings",
             words_seen, clouds_done, settings);
    $display("tb: kept %0d, non-finite %0d, range %0d, box %0d, ground %0d, input stalled %0d",
             reason_seen[RSN_KEEP], reason_seen[RSN_NOT_FINITE], reason_seen[RSN_RANGE],
             reason_seen[RSN_BOX], reason_seen[RSN_GROUND], stall_hits);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/prbgf_pkg.sv
rtl/core/prbgf_cfg_regs.sv
rtl/core/prbgf_classify.sv
rtl/core/prbgf_counters.sv
rtl/core/point_range_box_ground_filter_core.sv
tb/point_range_box_ground_filter_core_tb.sv
